// ===== rtl/qaar_pkg.sv =====
package qaar_pkg;

  localparam int XW = 34;   // CORDIC x and y, Q2.30 with headroom
  localparam int ZW = 32;   // residual angle in 2^-22 degree units
  localparam int SW = 18;   // sine and cosine with 16 fraction bits
  localparam int QW = 20;   // quaternion components, 16 fraction bits
  localparam int P1W = 52;  // quaternion times vector component
  localparam int TW = 38;   // first product components
  localparam int P2W = 58;  // first product times quaternion component
  localparam int RW = 44;   // second product before clipping

  localparam logic signed [17:0] HALF_TURN = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
  localparam logic signed [17:0] FULL_TURN = 18'sd46080;
  localparam logic signed [XW-1:0] GAIN_INV = 34'sd652032874;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } side_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic sat;
  } res_t;

  // Arctangent of 2^-i in degrees, scaled by 2^22 and rounded.
  function automatic logic signed [ZW-1:0] atan_q22(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 32'sd188743680;
      1: a = 32'sd111421900;
      2: a = 32'sd58872272;
      3: a = 32'sd29884485;
      4: a = 32'sd15000234;
      5: a = 32'sd7507429;
      6: a = 32'sd3754631;
      7: a = 32'sd1877430;
      8: a = 32'sd938729;
      9: a = 32'sd469366;
      10: a = 32'sd234683;
      11: a = 32'sd117342;
      12: a = 32'sd58671;
      13: a = 32'sd29335;
      14: a = 32'sd14668;
      15: a = 32'sd7334;
      16: a = 32'sd3667;
      17: a = 32'sd1833;
      18: a = 32'sd917;
      19: a = 32'sd458;
      20: a = 32'sd229;
      21: a = 32'sd115;
      22: a = 32'sd57;
      23: a = 32'sd29;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/quaternion_axis_angle_rotate_unit.sv =====
// Channel  Handshake            Word
// in       in_valid / in_ready  angle_deg, axis_x/y/z, vec_x/y/z
// out      out_valid/out_ready  out_x/y/z, saturated
//
// One word enters per cycle while in_ready is high. The depth is set by one
// register stage per CORDIC step plus the input, rounding, quaternion
// multiply and sum, and clip stages. The whole pipeline advances together;
// a two-entry output buffer keeps it moving until a second result waits,
// then in_ready drops. Reset clears only the valid bits.
module quaternion_axis_angle_rotate_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] angle_deg,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               saturated
);
  import qaar_pkg::*;

  localparam int D = CORDIC_STEPS + 8;

  logic [D-1:0] vld;
  logic en;
  logic ov;
  logic sv;
  res_t obuf;
  res_t sbuf;
  logic take;
  logic push;

  assign en = !sv;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  // Range reduction of the half angle.
  logic signed [17:0] h;
  cord_t c0;
  side_t s0;

  always_comb begin
    h = 18'(angle_deg);
    s0.flip = 1'b0;
    if (h > HALF_TURN) begin
      h = h - FULL_TURN;
    end else if (h < -HALF_TURN) begin
      h = h + FULL_TURN;
    end
    if (h > QUARTER_TURN) begin
      h = h - HALF_TURN;
      s0.flip = 1'b1;
    end else if (h < -QUARTER_TURN) begin
      h = h + HALF_TURN;
      s0.flip = 1'b1;
    end
    c0.x = GAIN_INV;
    c0.y = '0;
    c0.z = ZW'(h) <<< 15;
    s0.ax = axis_x;
    s0.ay = axis_y;
    s0.az = axis_z;
    s0.vx = vec_x;
    s0.vy = vec_y;
    s0.vz = vec_z;
  end

  cord_t cord_r [CORDIC_STEPS+1];
  side_t side_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cord_r[0] <= c0;
      side_r[0] <= s0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    qaar_cordic_step #(.STEP(k)) u_step (
      .clk (clk),
      .en  (en),
      .cin (cord_r[k]),
      .sin (side_r[k]),
      .cout(cord_r[k+1]),
      .sout(side_r[k+1])
    );
  end

  // Sign fix and rounding to 16 fraction bits.
  logic signed [XW-1:0] fx;
  logic signed [XW-1:0] fy;
  logic signed [XW-1:0] rs;
  logic signed [XW-1:0] rc;
  logic signed [SW-1:0] sin_a;
  logic signed [SW-1:0] cos_a;
  side_t side_a;

  always_comb begin
    fx = side_r[CORDIC_STEPS].flip ? -cord_r[CORDIC_STEPS].x : cord_r[CORDIC_STEPS].x;
    fy = side_r[CORDIC_STEPS].flip ? -cord_r[CORDIC_STEPS].y : cord_r[CORDIC_STEPS].y;
    rs = (fy + XW'(8192)) >>> 14;
    rc = (fx + XW'(8192)) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_a <= rs[SW-1:0];
      cos_a <= rc[SW-1:0];
      side_a <= side_r[CORDIC_STEPS];
    end
  end

  // Quaternion vector part: axis times sine.
  logic signed [33:0] px;
  logic signed [33:0] py;
  logic signed [33:0] pz;
  quat_t q_b;
  side_t side_b;

  always_comb begin
    px = (side_a.ax * sin_a + 34'sd8192) >>> 14;
    py = (side_a.ay * sin_a + 34'sd8192) >>> 14;
    pz = (side_a.az * sin_a + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_b.x <= px[QW-1:0];
      q_b.y <= py[QW-1:0];
      q_b.z <= pz[QW-1:0];
      q_b.w <= QW'(cos_a);
      side_b <= side_a;
    end
  end

  // First product q * v, one register per multiply.
  logic signed [P1W-1:0] p1 [12];
  quat_t q_p1;

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= q_b.x * side_b.vx;
      p1[1] <= q_b.y * side_b.vy;
      p1[2] <= q_b.z * side_b.vz;
      p1[3] <= q_b.w * side_b.vx;
      p1[4] <= q_b.y * side_b.vz;
      p1[5] <= q_b.z * side_b.vy;
      p1[6] <= q_b.w * side_b.vy;
      p1[7] <= q_b.z * side_b.vx;
      p1[8] <= q_b.x * side_b.vz;
      p1[9] <= q_b.w * side_b.vz;
      p1[10] <= q_b.x * side_b.vy;
      p1[11] <= q_b.y * side_b.vx;
      q_p1 <= q_b;
    end
  end

  logic signed [P1W+1:0] sw;
  logic signed [P1W+1:0] sx;
  logic signed [P1W+1:0] sy;
  logic signed [P1W+1:0] sz;
  logic signed [TW-1:0] tw;
  logic signed [TW-1:0] tx;
  logic signed [TW-1:0] ty;
  logic signed [TW-1:0] tz;
  quat_t q_t;

  always_comb begin
    sw = (-54'(p1[0]) - 54'(p1[1]) - 54'(p1[2]) + 54'sd32768) >>> 16;
    sx = (54'(p1[3]) + 54'(p1[4]) - 54'(p1[5]) + 54'sd32768) >>> 16;
    sy = (54'(p1[6]) + 54'(p1[7]) - 54'(p1[8]) + 54'sd32768) >>> 16;
    sz = (54'(p1[9]) + 54'(p1[10]) - 54'(p1[11]) + 54'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tw <= sw[TW-1:0];
      tx <= sx[TW-1:0];
      ty <= sy[TW-1:0];
      tz <= sz[TW-1:0];
      q_t <= q_p1;
    end
  end

  // Second product t * conj(q).
  logic signed [P2W-1:0] p2 [12];

  always_ff @(posedge clk) begin
    if (en) begin
      p2[0] <= tx * q_t.w;
      p2[1] <= tw * q_t.x;
      p2[2] <= ty * q_t.z;
      p2[3] <= tz * q_t.y;
      p2[4] <= ty * q_t.w;
      p2[5] <= tw * q_t.y;
      p2[6] <= tz * q_t.x;
      p2[7] <= tx * q_t.z;
      p2[8] <= tz * q_t.w;
      p2[9] <= tw * q_t.z;
      p2[10] <= tx * q_t.y;
      p2[11] <= ty * q_t.x;
    end
  end

  logic signed [P2W+1:0] ux;
  logic signed [P2W+1:0] uy;
  logic signed [P2W+1:0] uz;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  logic signed [RW-1:0] rz;

  always_comb begin
    ux = (60'(p2[0]) - 60'(p2[1]) - 60'(p2[2]) + 60'(p2[3]) + 60'sd32768) >>> 16;
    uy = (60'(p2[4]) - 60'(p2[5]) - 60'(p2[6]) + 60'(p2[7]) + 60'sd32768) >>> 16;
    uz = (60'(p2[8]) - 60'(p2[9]) - 60'(p2[10]) + 60'(p2[11]) + 60'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx <= ux[RW-1:0];
      ry <= uy[RW-1:0];
      rz <= uz[RW-1:0];
    end
  end

  // Clip to 32 bits: the value fits when all bits from 31 up agree.
  logic ox;
  logic oy;
  logic oz;
  res_t res_next;
  res_t res_o;

  always_comb begin
    ox = !((&rx[RW-1:31]) || !(|rx[RW-1:31]));
    oy = !((&ry[RW-1:31]) || !(|ry[RW-1:31]));
    oz = !((&rz[RW-1:31]) || !(|rz[RW-1:31]));
    res_next.x = ox ? (rx[RW-1] ? 32'sh80000000 : 32'sh7fffffff) : rx[31:0];
    res_next.y = oy ? (ry[RW-1] ? 32'sh80000000 : 32'sh7fffffff) : ry[31:0];
    res_next.z = oz ? (rz[RW-1] ? 32'sh80000000 : 32'sh7fffffff) : rz[31:0];
    res_next.sat = ox | oy | oz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_o <= res_next;
    end
  end

  // Output register with one skid entry behind it.
  assign take = ov && out_ready;
  assign push = en && vld[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (push) begin
      if (ov && !take) begin
        sbuf <= res_o;
        sv <= 1'b1;
      end else begin
        obuf <= res_o;
        ov <= 1'b1;
      end
    end else if (take) begin
      if (sv) begin
        obuf <= sbuf;
        sv <= 1'b0;
      end else begin
        ov <= 1'b0;
      end
    end
  end

  assign out_valid = ov;
  assign out_x = obuf.x;
  assign out_y = obuf.y;
  assign out_z = obuf.z;
  assign saturated = obuf.sat;

endmodule

// ===== rtl/qaar_cordic_step.sv =====
module qaar_cordic_step #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qaar_pkg::cord_t cin,
  input  qaar_pkg::side_t sin,
  output qaar_pkg::cord_t cout,
  output qaar_pkg::side_t sout
);
  import qaar_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_q22(STEP);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  cord_t c_next;

  always_comb begin
    dx = cin.y >>> STEP;
    dy = cin.x >>> STEP;
    if (cin.z >= 0) begin
      c_next.x = cin.x - dx;
      c_next.y = cin.y + dy;
      c_next.z = cin.z - ANG;
    end else begin
      c_next.x = cin.x + dx;
      c_next.y = cin.y - dy;
      c_next.z = cin.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c_next;
      sout <= sin;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic signed [15:0] ang;
    logic signed [15:0] ax, ay, az;
    logic signed [31:0] vx, vy, vz;
  } rot_word_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic sat;
  } rot_res_t;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 9;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] angle_deg = '0, axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic saturated;

  rot_res_t expected_rot[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int sat_seen = 0;
  longint cycles = 0;

  quaternion_axis_angle_rotate_unit #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .angle_deg(angle_deg), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
  );

  always #10 clk = ~clk;

  function automatic longint atan_deg(input int i);
    longint tbl[24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
      7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    return tbl[i];
  endfunction

  // Arithmetic right shift on a signed longint floors, so adding half rounds up.
  function automatic longint rnd(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic rot_res_t rotate_vector(input rot_word_t w);
    longint h, z, cx, cy, dx, dy, s16, c16, qx, qy, qz, qw;
    longint vx, vy, vz, tx, ty, tz, tw;
    logic flip;
    rot_res_t r;
    h = w.ang;
    vx = w.vx;
    vy = w.vy;
    vz = w.vz;
    flip = 1'b0;
    r.sat = 1'b0;
    if (h > 23040) h -= 46080;
    else if (h < -23040) h += 46080;
    if (h > 11520) begin
      h -= 23040;
      flip = 1'b1;
    end else if (h < -11520) begin
      h += 23040;
      flip = 1'b1;
    end
    z = h * 32768;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= atan_deg(i);
      end else begin
        cx += dx; cy -= dy; z += atan_deg(i);
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    s16 = rnd(cy, 14);
    c16 = rnd(cx, 14);
    qx = rnd(longint'(w.ax) * s16, 14);
    qy = rnd(longint'(w.ay) * s16, 14);
    qz = rnd(longint'(w.az) * s16, 14);
    qw = c16;
    tw = rnd(-(qx * vx) - (qy * vy) - (qz * vz), 16);
    tx = rnd(qw * vx + qy * vz - qz * vy, 16);
    ty = rnd(qw * vy + qz * vx - qx * vz, 16);
    tz = rnd(qw * vz + qx * vy - qy * vx, 16);
    r.x = clip(rnd(tx * qw - tw * qx - ty * qz + tz * qy, 16), r.sat);
    r.y = clip(rnd(ty * qw - tw * qy - tz * qx + tx * qz, 16), r.sat);
    r.z = clip(rnd(tz * qw - tw * qz - tx * qy + ty * qx, 16), r.sat);
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid drops only when a gap follows, so words can go back to back.
  task automatic send_word(input rot_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    expected_rot.push_back(rotate_vector(w));
    in_valid <= 1'b1;
    angle_deg <= w.ang;
    axis_x <= w.ax;
    axis_y <= w.ay;
    axis_z <= w.az;
    vec_x <= w.vx;
    vec_y <= w.vy;
    vec_z <= w.vz;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic rot_word_t make_word(input int ang, input int ax, input int ay,
                                          input int az, input int vx, input int vy,
                                          input int vz);
    rot_word_t w;
    w.ang = 16'(ang); w.ax = 16'(ax); w.ay = 16'(ay); w.az = 16'(az);
    w.vx = vx; w.vy = vy; w.vz = vz;
    return w;
  endfunction

  task automatic test_directed();
    // Angle extremes and fold boundaries, a zero axis, out-of-range axes,
    // and vectors large enough to saturate.
    send_word(make_word(0, 16384, 0, 0, 65536, 65536, 65536));
    send_word(make_word(5760, 0, 0, 16384, 65536, 0, 0));
    send_word(make_word(11520, 0, 16384, 0, 65536, 0, 0));
    send_word(make_word(11521, 16384, 0, 0, 0, 65536, 0));
    send_word(make_word(-11521, 16384, 0, 0, 0, 65536, 0));
    send_word(make_word(23040, 0, 0, 16384, 65536, 0, 0));
    send_word(make_word(23041, 0, 0, 16384, 65536, 0, 0));
    send_word(make_word(-23041, 0, 0, 16384, 65536, 0, 0));
    send_word(make_word(32767, 16384, 16384, 0, 100000, -7, 3));
    send_word(make_word(-32768, 0, 16384, 16384, -1, 1, 12345));
    send_word(make_word(3000, 0, 0, 0, 12345678, -9876543, 5));
    send_word(make_word(1000, -16384, -16384, -16384, 65536, 65536, 65536));
    send_word(make_word(2000, -32768, 32767, -32768, 2147483647, 1, -1));
    send_word(make_word(4000, 32767, 32767, 32767, 2147483647, 2147483647,
                        2147483647));
    send_word(make_word(7000, -32768, -32768, -32768, 32'sh80000000, 32'sh80000000,
                        32'sh80000000));
    send_word(make_word(0, 16384, 0, 0, 32'sh80000000, 2147483647, 32'sh80000000));
    send_word(make_word(-5760, 11585, 11585, 0, 1000000000, -1000000000, 1));
  endtask

  task automatic test_random();
    rot_word_t w;
    for (int n = 0; n < 800; n++) begin
      w.ang = 16'($urandom);
      w.ax = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      w.ay = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      w.az = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      w.vx = $urandom;
      w.vy = $urandom;
      w.vz = $urandom;
      // Most vectors are moderate so the rotation shows without clipping.
      if ($urandom_range(0, 2) != 0) begin
        w.vx = w.vx >>> $urandom_range(2, 24);
        w.vy = w.vy >>> $urandom_range(2, 24);
        w.vz = w.vz >>> $urandom_range(2, 24);
      end
      send_word(w);
    end
  endtask

  // Receiver stalls at random: mostly ready, sometimes short or long holds.
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_rot.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        rot_res_t e;
        e = expected_rot.pop_front();
        words_checked++;
        if (saturated) sat_seen++;
        if (out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %0d got %0d", e.z, out_z);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %0d got %0d", e.sat, saturated);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (expected_rot.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (expected_rot.size() != 0) begin
      $error("%0d results never arrived", expected_rot.size());
      errors++;
    end
    $display("Rotated %0d words, checked %0d results, %0d of them saturated.",
             words_sent, words_checked, sat_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qaar_pkg.sv
rtl/qaar_cordic_step.sv
rtl/quaternion_axis_angle_rotate_unit.sv
tb/sv/testbench.sv
